### design/rci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types and fixed sizes of the ray / cylinder intersection pipeline.
// ----------------------------------------------------------------------------
package rci_pkg;

	// register index decoded from paddr[2]
	localparam logic REG_RADIUS = 1'b0;

	localparam int SQ_STEPS  = 64;   // one root bit per step
	localparam int DIV_STEPS = 31;   // one quotient bit per step
	localparam int DIV_W     = 96;   // holds root numerator << FRAC_BITS and a << 31
	localparam int QDEPTH    = 2;    // result queue entries

	// s1..s5, discriminant, square root, numerators, divider load, divide, multiply, add
	localparam int NSTG = 5 + 1 + SQ_STEPS + 1 + 1 + DIV_STEPS + 2;

	localparam logic signed [31:0] TMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] TMIN = -32'sh7FFF_FFFF - 32'sh1;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

	typedef struct packed {
		ray_t               ray;
		logic [63:0]        a;
		logic signed [64:0] h;
		logic               kill;
		logic [127:0]       rem;
		logic [63:0]        root;
	} sqrt_stage_t;

	typedef struct packed {
		ray_t             ray;
		logic [63:0]      a;
		logic [1:0]       zero;
		logic [1:0]       sat;
		logic [DIV_W-1:0] rem0;
		logic [DIV_W-1:0] rem1;
		logic [30:0]      q0;
		logic [30:0]      q1;
	} div_stage_t;

	typedef struct packed {
		logic [1:0]         hv;
		logic signed [31:0] t0;
		logic signed [31:0] t1;
		logic signed [31:0] px0;
		logic signed [31:0] py0;
		logic signed [31:0] pz0;
		logic signed [31:0] px1;
		logic signed [31:0] py1;
		logic signed [31:0] pz1;
	} res_t;

	// clamp a 65-bit signed sum to the 32-bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (!v[64] && (|v[63:31])) begin
			r = TMAX;
		end else if (v[64] && !(&v[63:31])) begin
			r = TMIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### design/ray_cylinder_intersect_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_unit
// Fixed-point intersection of rays with an infinite cylinder about the z axis.
// ----------------------------------------------------------------------------
// Takes one ray per cycle (start and direction, signed Q.FRAC_BITS) and
// returns one result per positive root of a t^2 + 2h t + c = 0, larger root
// first, or a single result with hit clear when the ray misses, runs parallel
// to the axis, or has only non-positive roots. Each request passes a
// 105-stage pipeline: five stages of products and sums build a, h, c and
// the discriminant terms from 32x32 partial products, a 64-stage square
// root takes one root bit per stage, two 31-stage restoring dividers (one
// per root, side by side) form t, and two stages multiply t back into the
// hit point and clamp. Finished rays land in a two-entry result queue; the
// pipeline advances as long as that queue has room, so a ray with one
// result sustains one request per cycle, and a ray with two hits holds its
// queue entry until both of its results have gone out. The user must write
// the radius register over the APB port only while the unit is idle; the
// unit does not enforce this. pready is tied high.
module ray_cylinder_intersect_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// ray requests
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	// results
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic               final_of_ray,
	output logic signed [31:0] t_value,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y
);

	localparam int SQN = rci_pkg::SQ_STEPS;
	localparam int DVN = rci_pkg::DIV_STEPS;
	localparam int DW  = rci_pkg::DIV_W;
	localparam int NS  = rci_pkg::NSTG;
	localparam logic [30:0] RAD_RESET = 31'(1) << FRAC_BITS;

	// ---------------------------------------------------------------- config
	logic [30:0] radius_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == rci_pkg::REG_RADIUS) ? {1'b0, radius_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RAD_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == rci_pkg::REG_RADIUS)) begin
			radius_q <= pwdata[30:0];
		end
	end

	// ------------------------------------------------------- flow control
	// The whole pipeline moves as one while the result queue has room.
	logic          en;
	logic [NS-1:0] vld_s;
	logic [1:0]    cnt_q;

	assign en       = (cnt_q != 2'(rci_pkg::QDEPTH));
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	// ------------------------------------------------ s1: 32x32 products
	rci_pkg::ray_t      ray_s1;
	logic signed [63:0] dxx_s1, dyy_s1, sxx_s1, syy_s1, sxdx_s1, sydy_s1;
	logic [61:0]        r2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1  <= '{sx: start_x, sy: start_y, sz: start_z,
			             dx: dir_x, dy: dir_y, dz: dir_z};
			dxx_s1  <= 64'(dir_x) * 64'(dir_x);
			dyy_s1  <= 64'(dir_y) * 64'(dir_y);
			sxx_s1  <= 64'(start_x) * 64'(start_x);
			syy_s1  <= 64'(start_y) * 64'(start_y);
			sxdx_s1 <= 64'(start_x) * 64'(dir_x);
			sydy_s1 <= 64'(start_y) * 64'(dir_y);
			r2_s1   <= 62'(radius_q) * 62'(radius_q);
		end
	end

	// ------------------------------------------------- s2: a, h and c
	rci_pkg::ray_t      ray_s2;
	logic [63:0]        a_s2;
	logic signed [64:0] h_s2, c_s2;
	logic [63:0]        sq_sum;

	assign sq_sum = sxx_s1[63:0] + syy_s1[63:0];

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s2 <= ray_s1;
			a_s2   <= dxx_s1[63:0] + dyy_s1[63:0];
			h_s2   <= 65'(sxdx_s1) + 65'(sydy_s1);
			c_s2   <= $signed({1'b0, sq_sum}) - $signed({3'b0, r2_s1});
		end
	end

	// ---------------------------------------------- s3: magnitudes of h, c
	rci_pkg::ray_t      ray_s3;
	logic [63:0]        a_s3, hm_s3, cm_s3;
	logic signed [64:0] h_s3;
	logic               cneg_s3, azero_s3;
	logic signed [64:0] hneg, cneg_v;

	assign hneg   = -h_s2;
	assign cneg_v = -c_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s3   <= ray_s2;
			a_s3     <= a_s2;
			h_s3     <= h_s2;
			hm_s3    <= h_s2[64] ? hneg[63:0] : h_s2[63:0];
			cm_s3    <= c_s2[64] ? cneg_v[63:0] : c_s2[63:0];
			cneg_s3  <= c_s2[64];
			azero_s3 <= (a_s2 == 64'd0);
		end
	end

	// ------------------------------------ s4: partial products of h^2, a*|c|
	rci_pkg::ray_t      ray_s4;
	logic [63:0]        a_s4;
	logic signed [64:0] h_s4;
	logic               cneg_s4, azero_s4;
	logic [63:0]        hh00_s4, hh01_s4, hh11_s4;
	logic [63:0]        ac00_s4, ac01_s4, ac10_s4, ac11_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4   <= ray_s3;
			a_s4     <= a_s3;
			h_s4     <= h_s3;
			cneg_s4  <= cneg_s3;
			azero_s4 <= azero_s3;
			hh00_s4  <= 64'(hm_s3[31:0])  * 64'(hm_s3[31:0]);
			hh01_s4  <= 64'(hm_s3[31:0])  * 64'(hm_s3[63:32]);
			hh11_s4  <= 64'(hm_s3[63:32]) * 64'(hm_s3[63:32]);
			ac00_s4  <= 64'(a_s3[31:0])   * 64'(cm_s3[31:0]);
			ac01_s4  <= 64'(a_s3[31:0])   * 64'(cm_s3[63:32]);
			ac10_s4  <= 64'(a_s3[63:32])  * 64'(cm_s3[31:0]);
			ac11_s4  <= 64'(a_s3[63:32])  * 64'(cm_s3[63:32]);
		end
	end

	// ------------------------------------------- s5: assemble 128-bit terms
	rci_pkg::ray_t      ray_s5;
	logic [63:0]        a_s5;
	logic signed [64:0] h_s5;
	logic               cneg_s5, azero_s5;
	logic [127:0]       hh_s5, ac_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s5   <= ray_s4;
			a_s5     <= a_s4;
			h_s5     <= h_s4;
			cneg_s5  <= cneg_s4;
			azero_s5 <= azero_s4;
			hh_s5    <= {hh11_s4, 64'd0} + ({64'd0, hh01_s4} << 33) + {64'd0, hh00_s4};
			ac_s5    <= {ac11_s4, 64'd0} + ({64'd0, ac01_s4} << 32)
			          + ({64'd0, ac10_s4} << 32) + {64'd0, ac00_s4};
		end
	end

	// -------------------------------- s6..s70: discriminant and square root
	// sqrt_s[0] holds h^2 - a*c; sqrt_s[j+1] has settled root bit 63-j.
	rci_pkg::sqrt_stage_t sqrt_s [0:SQN];
	logic [128:0]         dsum;

	assign dsum = cneg_s5 ? ({1'b0, hh_s5} + {1'b0, ac_s5})
	                      : ({1'b0, hh_s5} - {1'b0, ac_s5});

	always_ff @(posedge clk) begin
		if (en) begin
			sqrt_s[0] <= '{ray: ray_s5, a: a_s5, h: h_s5,
			               kill: azero_s5 | dsum[128],
			               rem: dsum[127:0], root: 64'd0};
		end
	end

	for (genvar j = 0; j < SQN; j++) begin : g_sqrt
		localparam int B = SQN - 1 - j;
		logic [127:0] trial;
		logic         take;

		// (root + 2^B)^2 - root^2, root holding bits above B only
		assign trial = (128'(sqrt_s[j].root) << (B + 1)) | (128'(1) << (2 * B));
		assign take  = (sqrt_s[j].rem >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sqrt_s[j+1].ray  <= sqrt_s[j].ray;
				sqrt_s[j+1].a    <= sqrt_s[j].a;
				sqrt_s[j+1].h    <= sqrt_s[j].h;
				sqrt_s[j+1].kill <= sqrt_s[j].kill;
				sqrt_s[j+1].rem  <= take ? (sqrt_s[j].rem - trial) : sqrt_s[j].rem;
				sqrt_s[j+1].root <= take ? (sqrt_s[j].root | (64'(1) << B))
				                         : sqrt_s[j].root;
			end
		end
	end

	// ------------------------------------------ s71: root numerators -h +- s
	rci_pkg::ray_t      ray_s71;
	logic [63:0]        a_s71;
	logic [64:0]        n0_s71, n1_s71;
	logic [1:0]         pos_s71;
	logic signed [66:0] hx, sx_root, n0, n1;

	assign hx      = $signed({{2{sqrt_s[SQN].h[64]}}, sqrt_s[SQN].h});
	assign sx_root = $signed({3'b0, sqrt_s[SQN].root});
	assign n0      = sx_root - hx;
	assign n1      = -hx - sx_root;

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s71 <= sqrt_s[SQN].ray;
			a_s71   <= sqrt_s[SQN].a;
			n0_s71  <= n0[64:0];
			n1_s71  <= n1[64:0];
			pos_s71 <= {~n1[66] & (|n1) & ~sqrt_s[SQN].kill,
			            ~n0[66] & (|n0) & ~sqrt_s[SQN].kill};
		end
	end

	// ------------------------------------------- s72..s103: restoring divide
	// div_s[0] loads the scaled numerators and flags overflow past 2^31.
	rci_pkg::div_stage_t div_s [0:DVN];
	logic [DW-1:0]       num0, num1, lim;

	assign num0 = DW'(n0_s71) << FRAC_BITS;
	assign num1 = DW'(n1_s71) << FRAC_BITS;
	assign lim  = DW'(a_s71) << 31;

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= '{ray: ray_s71, a: a_s71, zero: ~pos_s71,
			              sat: {num1 >= lim, num0 >= lim},
			              rem0: num0, rem1: num1, q0: 31'd0, q1: 31'd0};
		end
	end

	for (genvar k = 0; k < DVN; k++) begin : g_div
		localparam int I = DVN - 1 - k;
		logic [DW-1:0] part;
		logic          ge0, ge1;

		assign part = DW'(div_s[k].a) << I;
		assign ge0  = (part <= div_s[k].rem0);
		assign ge1  = (part <= div_s[k].rem1);

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1].ray  <= div_s[k].ray;
				div_s[k+1].a    <= div_s[k].a;
				div_s[k+1].zero <= div_s[k].zero;
				div_s[k+1].sat  <= div_s[k].sat;
				div_s[k+1].rem0 <= ge0 ? (div_s[k].rem0 - part) : div_s[k].rem0;
				div_s[k+1].rem1 <= ge1 ? (div_s[k].rem1 - part) : div_s[k].rem1;
				div_s[k+1].q0   <= div_s[k].q0 | (ge0 ? (31'(1) << I) : 31'd0);
				div_s[k+1].q1   <= div_s[k].q1 | (ge1 ? (31'(1) << I) : 31'd0);
			end
		end
	end

	// ---------------------------------------------- s104: t and dir * t
	rci_pkg::ray_t      ray_s104;
	logic signed [31:0] t0_s104, t1_s104;
	logic signed [63:0] px0_s104, py0_s104, pz0_s104, px1_s104, py1_s104, pz1_s104;
	logic signed [31:0] t0, t1;
	rci_pkg::ray_t      rd;

	assign rd = div_s[DVN].ray;
	assign t0 = div_s[DVN].zero[0] ? 32'sd0
	          : div_s[DVN].sat[0]  ? rci_pkg::TMAX : $signed({1'b0, div_s[DVN].q0});
	assign t1 = div_s[DVN].zero[1] ? 32'sd0
	          : div_s[DVN].sat[1]  ? rci_pkg::TMAX : $signed({1'b0, div_s[DVN].q1});

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s104 <= rd;
			t0_s104  <= t0;
			t1_s104  <= t1;
			px0_s104 <= 64'(rd.dx) * 64'(t0);
			py0_s104 <= 64'(rd.dy) * 64'(t0);
			pz0_s104 <= 64'(rd.dz) * 64'(t0);
			px1_s104 <= 64'(rd.dx) * 64'(t1);
			py1_s104 <= 64'(rd.dy) * 64'(t1);
			pz1_s104 <= 64'(rd.dz) * 64'(t1);
		end
	end

	// ------------------------------------------- s105: hit points, clamp
	rci_pkg::res_t res_s105;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s105.hv  <= {t1_s104 != 32'sd0, t0_s104 != 32'sd0};
			res_s105.t0  <= t0_s104;
			res_s105.t1  <= t1_s104;
			res_s105.px0 <= rci_pkg::sat32(65'(ray_s104.sx) + 65'(px0_s104 >>> FRAC_BITS));
			res_s105.py0 <= rci_pkg::sat32(65'(ray_s104.sy) + 65'(py0_s104 >>> FRAC_BITS));
			res_s105.pz0 <= rci_pkg::sat32(65'(ray_s104.sz) + 65'(pz0_s104 >>> FRAC_BITS));
			res_s105.px1 <= rci_pkg::sat32(65'(ray_s104.sx) + 65'(px1_s104 >>> FRAC_BITS));
			res_s105.py1 <= rci_pkg::sat32(65'(ray_s104.sy) + 65'(py1_s104 >>> FRAC_BITS));
			res_s105.pz1 <= rci_pkg::sat32(65'(ray_s104.sz) + 65'(pz1_s104 >>> FRAC_BITS));
		end
	end

	// ---------------------------------------------------- result queue
	// Each entry is one ray; ph_q marks that its first hit has gone out.
	rci_pkg::res_t mem_q [0:rci_pkg::QDEPTH-1];
	logic          wr_q, rd_q, ph_q;
	logic          push, pop, pending, show1;
	rci_pkg::res_t head;

	assign head    = mem_q[rd_q];
	assign push    = en & vld_s[NS-1];
	assign pending = ~ph_q & head.hv[0] & head.hv[1];
	assign pop     = out_valid & out_ready & ~pending;
	assign show1   = ph_q | ~head.hv[0];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= res_s105;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			ph_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			// hold the entry for its second hit, drop it after the last result
			if (out_valid && out_ready) begin
				ph_q <= pending;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// ---------------------------------------------------- result fields
	assign out_valid    = (cnt_q != 2'd0);
	assign hit          = show1 ? head.hv[1] : 1'b1;
	assign final_of_ray = ~pending;
	assign t_value      = !hit ? 32'sd0 : (show1 ? head.t1 : head.t0);
	assign point_x      = !hit ? 32'sd0 : (show1 ? head.px1 : head.px0);
	assign point_y      = !hit ? 32'sd0 : (show1 ? head.py1 : head.py0);
	assign point_z      = !hit ? 32'sd0 : (show1 ? head.pz1 : head.pz0);
	// the radial normal of a z-axis cylinder is the hit point's x and y
	assign normal_x     = point_x;
	assign normal_y     = point_y;

endmodule

### design/rci_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rci_checker
// Port-level checks on the result stream of the intersection unit.
// ----------------------------------------------------------------------------
module rci_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               hit,
	input logic               final_of_ray,
	input logic signed [31:0] t_value,
	input logic signed [31:0] point_x,
	input logic signed [31:0] point_y,
	input logic signed [31:0] point_z,
	input logic signed [31:0] normal_x,
	input logic signed [31:0] normal_y
);

	// a miss closes its ray and carries zero fields
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> final_of_ray && t_value == 32'sd0 &&
		point_x == 32'sd0 && point_y == 32'sd0 && point_z == 32'sd0)
		else $error("miss result not final or not zeroed");

	// a hit lies ahead of the ray start
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !t_value[31] && t_value != 32'sd0)
		else $error("hit with non-positive t");

	a_normal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x == point_x && normal_y == point_y)
		else $error("normal differs from hit point");

	// a non-final result is always followed by the second hit
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !final_of_ray |=> out_valid && hit)
		else $error("second hit missing after non-final result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(t_value) && $stable(hit))
		else $error("stalled result changed");

endmodule

bind ray_cylinder_intersect_unit rci_checker u_rci_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hit          (hit),
	.final_of_ray (final_of_ray),
	.t_value      (t_value),
	.point_x      (point_x),
	.point_y      (point_y),
	.point_z      (point_z),
	.normal_x     (normal_x),
	.normal_y     (normal_y)
);

### test/ray_cylinder_intersect_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_cylinder_intersect_unit_test
// Self-checking bench for the ray / infinite cylinder intersection unit.
// ----------------------------------------------------------------------------
// An initial block queues ray requests (directed corner rays, then random
// rays mostly aimed near the cylinder) and computes the expected hits with an
// independent fixed-point predictor. A clocked driver feeds the requests, a
// clocked monitor compares every result field by field, and the radius is
// rewritten over APB between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module ray_cylinder_intersect_unit_test;

	localparam int FRAC  = 16;
	localparam int LAT   = 140;      // pipeline depth plus margin
	localparam int LIMIT = 20000;    // idle cycles before giving up
	localparam logic signed [31:0] S32_MAX = rci_pkg::TMAX;
	localparam logic signed [31:0] S32_MIN = rci_pkg::TMIN;

	typedef struct packed {
		logic signed [31:0] sx, sy, sz, dx, dy, dz;
	} ray_req_t;

	typedef struct packed {
		logic               hit;
		logic               last;
		logic signed [31:0] t, px, py, pz;
	} hit_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit, final_of_ray;
	logic signed [31:0] t_value, point_x, point_y, point_z, normal_x, normal_y;

	ray_req_t pending_rays[$];
	hit_rec_t expected_hits[$];
	logic [30:0] cyl_radius = 31'd65536;
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_off = 1'b0;
	int hold_cycles = 0;
	int errors = 0;
	int idle_count = 0;
	int req_sent = 0;

	ray_cylinder_intersect_unit #(.FRAC_BITS(FRAC)) i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor square root of a 128-bit value, one bit per pass
	function automatic logic [63:0] isqrt128(input logic [127:0] v);
		logic [63:0] s;
		logic [63:0] c;
		s = '0;
		for (int i = 63; i >= 0; i--) begin
			c = s | (64'd1 << i);
			if ({64'd0, c} * {64'd0, c} <= v) s = c;
		end
		return s;
	endfunction

	// quantized root t = floor(n * 2^F / a), zero when n is not positive, S32_MAX on overflow
	function automatic logic signed [31:0] root_param(input logic signed [129:0] n,
			input logic [63:0] a);
		logic [129:0] num;
		logic [129:0] q;
		if (n <= 0) return 32'sd0;
		num = n << FRAC;
		q = num / a;
		if (q >= 130'h8000_0000) return S32_MAX;
		return q[31:0];
	endfunction

	// start + floor(dir * t / 2^F), clamped to 32 bits
	function automatic logic signed [31:0] hit_coord(input logic signed [31:0] s,
			input logic signed [31:0] d, input logic signed [31:0] t);
		logic signed [63:0] p;
		logic signed [65:0] v;
		p = 64'(d) * 64'(t);
		v = 66'(s) + 66'(p >>> FRAC);
		if (v > 66'sd2147483647) return S32_MAX;
		if (v < -66'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction

	// work out the result list of one ray
	task automatic predict_hits(input ray_req_t r);
		logic signed [129:0] a, h, c, disc, nh;
		logic [63:0] root;
		logic signed [31:0] ts[2];
		int n;
		hit_rec_t e;
		a = 130'(r.dx) * 130'(r.dx) + 130'(r.dy) * 130'(r.dy);
		h = 130'(r.sx) * 130'(r.dx) + 130'(r.sy) * 130'(r.dy);
		c = 130'(r.sx) * 130'(r.sx) + 130'(r.sy) * 130'(r.sy)
			- 130'($signed({1'b0, cyl_radius})) * 130'($signed({1'b0, cyl_radius}));
		disc = h * h - a * c;
		n = 0;
		if (a != 0 && disc >= 0) begin
			root = isqrt128(disc[127:0]);
			nh = -h;
			ts[0] = root_param(nh + 130'(root), a[63:0]);
			ts[1] = root_param(nh - 130'(root), a[63:0]);
			for (int k = 0; k < 2; k++) begin
				if (ts[k] > 0) begin
					e.hit = 1'b1;
					e.last = 1'b0;
					e.t = ts[k];
					e.px = hit_coord(r.sx, r.dx, ts[k]);
					e.py = hit_coord(r.sy, r.dy, ts[k]);
					e.pz = hit_coord(r.sz, r.dz, ts[k]);
					expected_hits = {expected_hits, e};
					n++;
				end
			end
		end
		if (n == 0) begin
			e = '0;
			expected_hits = {expected_hits, e};
		end
		expected_hits[$].last = 1'b1;
	endtask

	task automatic queue_ray(input logic signed [31:0] sx, sy, sz, dx, dy, dz);
		ray_req_t r;
		r = '{sx, sy, sz, dx, dy, dz};
		pending_rays = {pending_rays, r};
		predict_hits(r);
	endtask

	// random ray: mostly small coordinates near the cylinder, some full range
	task automatic queue_random_ray();
		logic signed [31:0] v[6];
		int mode;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < 6; i++) begin
			if (mode < 7) v[i] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			else v[i] = $urandom;
		end
		if (mode == 0) begin
			v[3] = '0;
			v[4] = '0;
		end
		queue_ray(v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	// APB write: setup then access; drive off the rising edge
	task automatic write_radius(input logic [30:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {rci_pkg::REG_RADIUS, 2'b00};
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cyl_radius = value;
	endtask

	// drain: wait until all requests left and all results arrived, then settle
	task automatic drain();
		wait (pending_rays.size() == 0 && expected_hits.size() == 0);
		repeat (LAT) @(posedge clk);
	endtask

	// driver: hold valid and payload until accepted, then advance
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			void'(pending_rays.pop_front());
			req_sent++;
		end
		if (pending_rays.size() > (in_valid && in_ready ? 0 : 0) &&
			(in_valid && !in_ready || $urandom_range(0, 99) >= send_idle_pct)) begin
			in_valid <= 1'b1;
			start_x <= pending_rays[0].sx;
			start_y <= pending_rays[0].sy;
			start_z <= pending_rays[0].sz;
			dir_x <= pending_rays[0].dx;
			dir_y <= pending_rays[0].dy;
			dir_z <= pending_rays[0].dz;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		hit_rec_t e;
		if (out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				$error("unexpected result: hit=%0b t=%0d", hit, t_value);
				errors++;
			end else begin
				e = expected_hits.pop_front();
				if (hit !== e.hit) begin
					$error("hit: expected %0b, got %0b", e.hit, hit); errors++;
				end
				if (final_of_ray !== e.last) begin
					$error("final_of_ray: expected %0b, got %0b", e.last, final_of_ray);
					errors++;
				end
				if (t_value !== e.t) begin
					$error("t_value: expected %0d, got %0d", e.t, t_value); errors++;
				end
				if (point_x !== e.px) begin
					$error("point_x: expected %0d, got %0d", e.px, point_x); errors++;
				end
				if (point_y !== e.py) begin
					$error("point_y: expected %0d, got %0d", e.py, point_y); errors++;
				end
				if (point_z !== e.pz) begin
					$error("point_z: expected %0d, got %0d", e.pz, point_z); errors++;
				end
				if (normal_x !== e.px) begin
					$error("normal_x: expected %0d, got %0d", e.px, normal_x); errors++;
				end
				if (normal_y !== e.py) begin
					$error("normal_y: expected %0d, got %0d", e.py, normal_y); errors++;
				end
			end
		end
		// receiver: long hold-off counted here, otherwise random stalls
		if (hold_off && hold_cycles < 400) begin
			hold_cycles <= hold_cycles + 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog: count cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: radius at reset (1.0)
		queue_ray(-32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0);          // two hits
		queue_ray(0, 0, 0, 32'sh0001_0000, 0, 32'sh0000_8000);           // inside: one hit
		queue_ray(32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 0);           // behind: none
		queue_ray(0, 0, 32'sh0001_0000, 0, 0, 32'sh0001_0000);           // parallel to axis
		queue_ray(-32'sh0002_0000, 32'sh0002_0000, 0, 32'sh0001_0000, 0, 0); // miss
		queue_ray(-32'sh0002_0000, 32'sh0001_0000, 0, 32'sh0001_0000, 0, 0); // tangent
		queue_ray(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX); // extremes
		queue_ray(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN);
		queue_ray(-32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1, -32'sd1);   // t saturates
		queue_ray(0, 0, S32_MAX, 32'sh0000_0001, 0, S32_MAX);            // point saturates
		queue_ray(S32_MIN, 0, 0, S32_MAX, 0, S32_MIN);
		queue_ray(-32'sh0002_0000, 0, S32_MIN, 32'sh0001_0000, 0, S32_MIN);
		drain();

		write_radius(31'd0);
		queue_ray(-32'sh0001_0000, 0, 0, 32'sh0001_0000, 0, 0);
		queue_ray(0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0);
		drain();
		write_radius(31'h7FFF_FFFF);
		queue_ray(0, 0, 0, 32'sh0001_0000, 0, 0);
		queue_ray(S32_MIN, S32_MAX, 0, 32'sd1, -32'sd1, 32'sd5);
		queue_ray(0, 0, 0, S32_MAX, S32_MIN, 0);
		drain();
		write_radius(31'h0003_0000);

		// phase one: sender idles a quarter, receiver two thirds
		send_idle_pct = 24;
		recv_idle_pct = 67;
		for (int i = 0; i < 250; i++) queue_random_ray();
		drain();
		write_radius(31'($urandom_range(1, 31'h0008_0000)));

		// phase two: roles swapped, with a long receiver hold-off
		send_idle_pct = 67;
		recv_idle_pct = 24;
		hold_off = 1'b1;
		for (int i = 0; i < 250; i++) queue_random_ray();
		drain();
		write_radius(31'h0001_8000);

		// phase three: full rate both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < 250; i++) queue_random_ray();
		drain();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

### files.f
design/rci_pkg.sv
design/ray_cylinder_intersect_unit.sv
design/rci_checker.sv
test/ray_cylinder_intersect_unit_test.sv
